// ----- rtl/spf_pkg.sv -----
package spf_pkg;

   // table geometry
   localparam int MAX_N       = 1024;
   localparam int DEPTH       = MAX_N + 1;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int SPF_W       = 5;
   localparam int VAL_W       = 11;
   localparam int CMP_W       = (ADDR_W > VAL_W) ? ADDR_W : VAL_W;
   localparam int IDX_W       = (ADDR_W + 1) / 2 + 1;
   localparam int SQ_W        = 2 * IDX_W;
   localparam int MAX_RESULTS = 10;
   localparam int K_W         = $clog2(MAX_RESULTS);
   localparam int CNT_W       = $clog2(ADDR_W) + 1;

   // func codes
   localparam logic FUNC_BUILD  = 1'b0;
   localparam logic FUNC_FACTOR = 1'b1;

   typedef struct packed {
      logic             func;
      logic [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [VAL_W-1:0] factor;
      logic             last;
      logic             error;
   } rsp_type;

endpackage

// ----- rtl/spf_ram.sv -----
module spf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/spf_sieve_factorizer_top.sv -----
// Smallest-prime-factor sieve and factorizer.
//
// Input: an item (func, value) is taken at a clock edge with start high and
// busy low. func build (0) clears the table over entries 0..limit, then
// sieves up to the limit (saturated to MAX_N) and returns one result with
// factor 0 and last set. func factor (1) walks the table and returns the
// prime factors of value in ascending order, the final one marked by last.
// 0 and 1 come back as themselves; a value above the built limit gives one
// result with error set. Results appear on rsp_item for one cycle each,
// marked by rsp_valid; the receiver cannot stall, so nothing backs up.
// Steps: a build clears entries 0..limit, then checks each sieve index up
// to sqrt(limit) and, for each prime index, visits its multiples from its
// square up to the limit. The table RAM (one write, one registered read
// port) paces the sieve: each multiple costs one read and, where the entry
// is still zero, one write, overlapped. A factor item reads the table once
// per prime factor and divides by it with the one-bit-per-cycle divider;
// 0, 1 and out-of-range values are answered without raising busy.
// Reset clears the control state and the built limit; the table is then
// never read until a build has cleared the entries it covers.
module spf_sieve_factorizer_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  spf_pkg::req_type req_item,
   output logic             busy,
   output logic             rsp_valid,
   output spf_pkg::rsp_type rsp_item
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_CLEAR   = 4'd1;
   localparam logic [3:0] S_OUT_RD  = 4'd2;
   localparam logic [3:0] S_OUT_CHK = 4'd3;
   localparam logic [3:0] S_SIEVE   = 4'd4;
   localparam logic [3:0] S_F_RD    = 4'd5;
   localparam logic [3:0] S_F_CHK   = 4'd6;
   localparam logic [3:0] S_DIV     = 4'd7;

   logic [3:0]                  state_ff, state_in;
   logic [spf_pkg::ADDR_W-1:0]  lim_ff, lim_in;     // built table limit
   logic [spf_pkg::ADDR_W-1:0]  clr_ff, clr_in;     // clear sweep address
   logic [spf_pkg::IDX_W-1:0]   idx_ff, idx_in;     // sieve prime candidate
   logic [spf_pkg::ADDR_W:0]    mul_ff, mul_in;     // current multiple
   logic [spf_pkg::ADDR_W-1:0]  pend_addr_ff, pend_addr_in;
   logic                        pend_vld_ff, pend_vld_in;
   logic [spf_pkg::ADDR_W-1:0]  num_ff, num_in;     // number / quotient
   logic [spf_pkg::SPF_W-1:0]   div_ff, div_in;     // divisor
   logic [spf_pkg::SPF_W-1:0]   rem_ff, rem_in;
   logic [spf_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [spf_pkg::K_W-1:0]     k_ff, k_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   spf_pkg::rsp_type            rsp_item_ff, rsp_item_in;

   logic                        wr_en;
   logic [spf_pkg::ADDR_W-1:0]  wr_addr;
   logic [spf_pkg::SPF_W-1:0]   wr_data;
   logic [spf_pkg::ADDR_W-1:0]  rd_addr;
   logic [spf_pkg::SPF_W-1:0]   rd_data;

   logic [spf_pkg::SQ_W-1:0]    idx_sq;
   logic [spf_pkg::SPF_W:0]     shl_rem;
   logic [spf_pkg::SPF_W:0]     sub_rem;
   logic                        accept;

   spf_ram #(
      .WIDTH(spf_pkg::SPF_W),
      .DEPTH(spf_pkg::DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign accept  = start && !busy;
   assign idx_sq  = spf_pkg::SQ_W'(idx_ff) * spf_pkg::SQ_W'(idx_ff);
   // restoring divider step, one quotient bit per cycle
   assign shl_rem = {rem_ff, num_ff[spf_pkg::ADDR_W-1]};
   assign sub_rem = shl_rem - {1'b0, div_ff};

   always_comb begin
      state_in     = state_ff;
      lim_in       = lim_ff;
      clr_in       = clr_ff;
      idx_in       = idx_ff;
      mul_in       = mul_ff;
      pend_addr_in = pend_addr_ff;
      pend_vld_in  = 1'b0;
      num_in       = num_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;
      wr_en        = 1'b0;
      wr_addr      = pend_addr_ff;
      wr_data      = spf_pkg::SPF_W'(idx_ff);
      rd_addr      = num_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_item.func == spf_pkg::FUNC_BUILD) begin
                  if (spf_pkg::CMP_W'(req_item.value) > spf_pkg::CMP_W'(spf_pkg::MAX_N)) begin
                     lim_in = spf_pkg::ADDR_W'(spf_pkg::MAX_N);
                  end else begin
                     lim_in = spf_pkg::ADDR_W'(req_item.value);
                  end
                  clr_in   = '0;
                  state_in = S_CLEAR;
               end else if (req_item.value <= spf_pkg::VAL_W'(1)) begin
                  rsp_valid_in = 1'b1;
                  rsp_item_in  = '{factor: req_item.value, last: 1'b1, error: 1'b0};
               end else if (spf_pkg::CMP_W'(req_item.value) > spf_pkg::CMP_W'(lim_ff)) begin
                  rsp_valid_in = 1'b1;
                  rsp_item_in  = '{factor: '0, last: 1'b1, error: 1'b1};
               end else begin
                  num_in   = spf_pkg::ADDR_W'(req_item.value);
                  k_in     = '0;
                  state_in = S_F_RD;
               end
            end
         end

         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == lim_ff) begin
               idx_in   = spf_pkg::IDX_W'(2);
               state_in = S_OUT_RD;
            end
         end

         S_OUT_RD: begin
            rd_addr = spf_pkg::ADDR_W'(idx_ff);
            if (idx_sq > spf_pkg::SQ_W'(lim_ff)) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = '{factor: '0, last: 1'b1, error: 1'b0};
               state_in     = S_IDLE;
            end else begin
               state_in = S_OUT_CHK;
            end
         end

         S_OUT_CHK: begin
            if (rd_data != '0) begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_OUT_RD;
            end else begin
               mul_in   = (spf_pkg::ADDR_W + 1)'(idx_sq);
               state_in = S_SIEVE;
            end
         end

         S_SIEVE: begin
            // write back the multiple read last cycle, read the next one
            wr_en   = pend_vld_ff && (rd_data == '0);
            rd_addr = mul_ff[spf_pkg::ADDR_W-1:0];
            if (mul_ff <= (spf_pkg::ADDR_W + 1)'(lim_ff)) begin
               pend_addr_in = mul_ff[spf_pkg::ADDR_W-1:0];
               pend_vld_in  = 1'b1;
               mul_in       = mul_ff + (spf_pkg::ADDR_W + 1)'(idx_ff);
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_OUT_RD;
            end
         end

         S_F_RD: begin
            rd_addr  = num_ff;
            state_in = S_F_CHK;
         end

         S_F_CHK: begin
            rsp_valid_in = 1'b1;
            if ((k_ff < spf_pkg::K_W'(spf_pkg::MAX_RESULTS - 1)) && (rd_data != '0)) begin
               rsp_item_in = '{factor: spf_pkg::VAL_W'(rd_data), last: 1'b0, error: 1'b0};
               k_in        = k_ff + 1'b1;
               div_in      = rd_data;
               rem_in      = '0;
               cnt_in      = '0;
               state_in    = S_DIV;
            end else begin
               rsp_item_in = '{factor: spf_pkg::VAL_W'(num_ff), last: 1'b1, error: 1'b0};
               state_in    = S_IDLE;
            end
         end

         S_DIV: begin
            if (shl_rem >= {1'b0, div_ff}) begin
               rem_in = sub_rem[spf_pkg::SPF_W-1:0];
               num_in = {num_ff[spf_pkg::ADDR_W-2:0], 1'b1};
            end else begin
               rem_in = shl_rem[spf_pkg::SPF_W-1:0];
               num_in = {num_ff[spf_pkg::ADDR_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == spf_pkg::CNT_W'(spf_pkg::ADDR_W - 1)) begin
               state_in = S_F_RD;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lim_ff       <= '0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lim_ff       <= lim_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      clr_ff       <= clr_in;
      idx_ff       <= idx_in;
      mul_ff       <= mul_in;
      pend_addr_ff <= pend_addr_in;
      num_ff       <= num_in;
      div_ff       <= div_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      k_ff         <= k_in;
      rsp_item_ff  <= rsp_item_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // table is written only while a build runs
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_CLEAR || state_ff == S_SIEVE))
      else $error("table write outside build");

   // no write ever lands above the built limit
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (wr_addr <= lim_ff))
      else $error("table write above limit");

   // error result is a lone final result with zero factor
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.error) |-> (rsp_item.last && rsp_item.factor == '0))
      else $error("malformed error result");

   // an accepted build always occupies the block
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_item.func == spf_pkg::FUNC_BUILD) |=> busy)
      else $error("build did not start");

endmodule
